// File: design/tftp_packet_parser_macros.svh
// Assertion macros for the TFTP packet parser.
// Relies on clk and rst_n being visible where the macros are used.
`ifndef TFTP_PACKET_PARSER_MACROS_SVH
`define TFTP_PACKET_PARSER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TFPP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define TFPP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tfpp_pkg.sv
// Shared constants, codes and types for the TFTP packet parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tfpp_pkg;

  localparam int FILENAME_LIMIT = 256;
  localparam int MODE_LIMIT     = 16;
  localparam int DATA_LIMIT     = 512;
  localparam int MSG_LIMIT      = 512;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [10:0] POS_MAX    = 11'd2047;
  localparam logic [10:0] DATA_LIM_W = 11'(DATA_LIMIT);
  localparam logic [10:0] MSG_LIM_W  = 11'(MSG_LIMIT);
  localparam logic [9:0]  NAME_LIM_W = 10'(FILENAME_LIMIT);
  localparam logic [9:0]  MODE_LIM_W = 10'(MODE_LIMIT);

  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  localparam logic [1:0] PH_NAME    = 2'd0;
  localparam logic [1:0] PH_MODE    = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [1:0] SEC_DATA  = 2'd2;
  localparam logic [1:0] SEC_ERMSG = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_OP    = 3'd2;
  localparam logic [2:0] ST_BAD_NAME  = 3'd3;
  localparam logic [2:0] ST_BAD_MODE  = 3'd4;
  localparam logic [2:0] ST_SHORT_HDR = 3'd5;
  localparam logic [2:0] ST_DATA_LONG = 3'd6;
  localparam logic [2:0] ST_ACK_LEN   = 3'd7;

  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_STATUS  = 1'b1;

  typedef struct packed {
    logic        has_pay;
    logic [1:0]  section;
    logic [7:0]  value;
    logic        has_stat;
    logic [2:0]  status;
    logic [15:0] opcode;
    logic [15:0] blk;
    logic [10:0] len;
    logic        kept;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  section;
    logic [7:0]  value;
    logic        last;
    logic [2:0]  status;
    logic [15:0] opcode;
    logic [15:0] blk;
    logic [10:0] len;
    logic        kept;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: design/tfpp_front.sv
// Front end: takes packet words, tracks header and string state, builds jobs.
// Depends on tfpp_pkg.
`timescale 1ns / 1ps

module tfpp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_packet_byte,
  input  logic          in_end_of_packet,
  input  tfpp_pkg::qstat_t q_stat,
  output logic          push,
  output tfpp_pkg::job_t push_job
);
  import tfpp_pkg::*;

  logic [10:0] bp_r, bp_nxt, bp_inc;
  logic [15:0] op_r, op_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [8:0]  sl_r, sl_nxt;
  logic [15:0] bc_r, bc_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [9:0]  sl_next, lim;
  logic        req, pay, accept;
  job_t        job;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (job.has_pay || job.has_stat);
  assign push_job = job;

  always_comb begin
    bp_nxt  = bp_r;
    op_nxt  = op_r;
    ph_nxt  = ph_r;
    sl_nxt  = sl_r;
    bc_nxt  = bc_r;
    st_nxt  = st_r;
    job     = '0;
    bp_inc  = (bp_r < POS_MAX) ? bp_r + 11'd1 : bp_r;
    req     = (op_r == OP_RRQ) || (op_r == OP_WRQ);
    sl_next = {1'b0, sl_r} + 10'd1;
    lim     = (ph_r == PH_NAME) ? NAME_LIM_W : MODE_LIM_W;
    if (ph_r == PH_PAYLOAD) begin
      if (op_r == OP_DATA && bp_r < DATA_LIM_W) begin
        job.has_pay = 1'b1;
        job.section = SEC_DATA;
      end else if (op_r == OP_ERROR && bp_r < MSG_LIM_W - 11'd1) begin
        job.has_pay = 1'b1;
        job.section = SEC_ERMSG;
      end
      bp_nxt = bp_inc;
    end else begin
      if (bp_r == 11'd0) begin
        op_nxt = {in_packet_byte, 8'h00};
      end else if (bp_r == 11'd1) begin
        op_nxt = {op_r[15:8], in_packet_byte};
      end else if (req) begin
        if (st_r == ST_OK && ph_r != PH_DONE) begin
          if (in_packet_byte == 8'h00) begin
            ph_nxt = (ph_r == PH_NAME) ? PH_MODE : PH_DONE;
            sl_nxt = '0;
          end else if (sl_next >= lim) begin
            st_nxt = (ph_r == PH_NAME) ? ST_BAD_NAME : ST_BAD_MODE;
          end else begin
            job.has_pay = 1'b1;
            job.section = ph_r;
            sl_nxt      = sl_next[8:0];
          end
        end
      end else if (bp_r == 11'd2) begin
        bc_nxt = {in_packet_byte, 8'h00};
      end else if (bp_r == 11'd3) begin
        bc_nxt = {bc_r[15:8], in_packet_byte};
      end
      bp_nxt = bp_inc;
      if (bp_inc == 11'd4 && op_nxt >= OP_DATA && op_nxt <= OP_ERROR) begin
        ph_nxt = PH_PAYLOAD;
        bp_nxt = '0;
      end
    end
    job.value = in_packet_byte;

    pay = (ph_nxt == PH_PAYLOAD);
    if (in_end_of_packet) begin
      job.has_stat = 1'b1;
      job.opcode   = op_nxt;
      job.blk      = pay ? bc_nxt : 16'h0000;
      job.len      = pay ? bp_nxt : ((bp_nxt > 11'd4) ? bp_nxt - 11'd4 : 11'd0);
      job.kept     = pay && op_nxt == OP_ERROR && bp_nxt >= 11'd1 && bp_nxt < MSG_LIM_W;
      if (!pay && bp_nxt < 11'd2) begin
        job.status = ST_SHORT;
      end else if (op_nxt == OP_RRQ || op_nxt == OP_WRQ) begin
        if (st_nxt == ST_OK && ph_nxt == PH_NAME) job.status = ST_BAD_NAME;
        else if (st_nxt == ST_OK && ph_nxt == PH_MODE) job.status = ST_BAD_MODE;
        else job.status = st_nxt;
      end else if (op_nxt == OP_DATA) begin
        job.status = !pay ? ST_SHORT_HDR : ((bp_nxt > DATA_LIM_W) ? ST_DATA_LONG : ST_OK);
      end else if (op_nxt == OP_ACK) begin
        job.status = (pay && bp_nxt == 11'd0) ? ST_OK : ST_ACK_LEN;
      end else if (op_nxt == OP_ERROR) begin
        job.status = pay ? ST_OK : ST_SHORT_HDR;
      end else begin
        job.status = ST_BAD_OP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= '0;
      op_r <= '0;
      ph_r <= PH_NAME;
      sl_r <= '0;
      bc_r <= '0;
      st_r <= ST_OK;
    end else if (accept) begin
      if (in_end_of_packet) begin
        bp_r <= '0;
        op_r <= '0;
        ph_r <= PH_NAME;
        sl_r <= '0;
        bc_r <= '0;
        st_r <= ST_OK;
      end else begin
        bp_r <= bp_nxt;
        op_r <= op_nxt;
        ph_r <= ph_nxt;
        sl_r <= sl_nxt;
        bc_r <= bc_nxt;
        st_r <= st_nxt;
      end
    end
  end

endmodule

// File: design/tfpp_queue.sv
// Short job queue between the front end and the result stage.
// Depends on tfpp_pkg.
`timescale 1ns / 1ps

module tfpp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tfpp_pkg::job_t   push_job,
  input  logic             pop,
  output tfpp_pkg::job_t   head,
  output tfpp_pkg::qstat_t q_stat
);
  import tfpp_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_pop;

  assign q_stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem_r[rp_r];
  assign do_pop       = pop && !q_stat.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + (QAW+1)'(1);
    else if (!push && do_pop) cnt_nxt = cnt_r - (QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (do_pop) rp_r <= rp_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: design/tfpp_back.sv
// Result stage: splits each job into payload and status words, holds them
// in an output register. Depends on tfpp_pkg.
`timescale 1ns / 1ps

module tfpp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tfpp_pkg::job_t   head,
  input  tfpp_pkg::qstat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output tfpp_pkg::res_t   res
);
  import tfpp_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic sub_r, sub_nxt;
  res_t res_r, res_nxt;
  logic load;

  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign load      = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sub_nxt       = sub_r;
    res_nxt       = res_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        res_nxt = '0;
        if (head.has_pay && !sub_r) begin
          res_nxt.kind    = RK_PAYLOAD;
          res_nxt.section = head.section;
          res_nxt.value   = head.value;
          res_nxt.last    = !head.has_stat;
          sub_nxt         = head.has_stat;
          pop             = !head.has_stat;
        end else begin
          res_nxt.kind   = RK_STATUS;
          res_nxt.last   = 1'b1;
          res_nxt.status = head.status;
          res_nxt.opcode = head.opcode;
          res_nxt.blk    = head.blk;
          res_nxt.len    = head.len;
          res_nxt.kept   = head.kept;
          sub_nxt        = 1'b0;
          pop            = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

endmodule

// File: design/tftp_packet_parser.sv
// TFTP packet parser, one packet byte per cycle in, one result per cycle out, each side
// while not stalled. Accepts a new word every cycle while the four-deep job queue has
// room; the result register emits one word per cycle while out_ready is high, so a final
// byte that also carries a payload byte yields a payload word and then a status word.
// Such a byte closes a packet of at least three bytes, so with the output always ready
// the queue never fills; only a stalled receiver fills it, and then in_ready drops until
// an entry is freed. Each result passes through the job queue and the result register.
// Depends on tfpp_pkg, tfpp_front, tfpp_queue, tfpp_back and the macro header.
`timescale 1ns / 1ps
`include "tftp_packet_parser_macros.svh"

module tftp_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_end_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [1:0]  out_section,
  output logic [7:0]  out_payload_value,
  output logic        out_last_of_run,
  output logic [2:0]  out_parse_status,
  output logic [15:0] out_opcode_seen,
  output logic [15:0] out_block_or_code,
  output logic [10:0] out_payload_length,
  output logic        out_message_kept
);
  import tfpp_pkg::*;

  qstat_t q_stat;
  job_t   push_job, head;
  res_t   res;
  logic   push, pop;

  tfpp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_packet_byte   (in_packet_byte),
    .in_end_of_packet (in_end_of_packet),
    .q_stat           (q_stat),
    .push             (push),
    .push_job         (push_job)
  );

  tfpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  tfpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_result_kind    = res.kind;
  assign out_section        = res.section;
  assign out_payload_value  = res.value;
  assign out_last_of_run    = res.last;
  assign out_parse_status   = res.status;
  assign out_opcode_seen    = res.opcode;
  assign out_block_or_code  = res.blk;
  assign out_payload_length = res.len;
  assign out_message_kept   = res.kept;

  `TFPP_CHECK(a_full_stalls, q_stat.full, !in_ready, "input taken while queue full")
  `TFPP_CHECK(a_stat_last, out_valid && out_result_kind == RK_STATUS, out_last_of_run, "status word without last flag")
  `TFPP_CHECK(a_pay_clean, out_valid && out_result_kind == RK_PAYLOAD, out_parse_status == ST_OK && out_opcode_seen == 16'h0000, "payload word carries status fields")
  `TFPP_CHECK_NEXT(a_split_pair, out_valid && out_ready && out_result_kind == RK_PAYLOAD && !out_last_of_run, out_valid && out_result_kind == RK_STATUS, "status word does not follow its payload word")

endmodule

// File: test/tftp_packet_parser_tb.sv
// Testbench for tftp_packet_parser: byte-level TFTP packets in, payload and status words out.
// Predicts every result word on its own and compares field by field; uses tfpp_pkg for codes.
`timescale 1ns / 1ps

module tftp_packet_parser_tb;
  import tfpp_pkg::*;

  localparam int RANDOM_BYTES  = 490;
  localparam int CALM_TAIL     = 150;
  localparam int HOLD_CYCLES   = 120;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_packet_byte;
  logic        in_end_of_packet;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_kind;
  logic [1:0]  out_section;
  logic [7:0]  out_payload_value;
  logic        out_last_of_run;
  logic [2:0]  out_parse_status;
  logic [15:0] out_opcode_seen;
  logic [15:0] out_block_or_code;
  logic [10:0] out_payload_length;
  logic        out_message_kept;

  tftp_packet_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_packet_byte     (in_packet_byte),
    .in_end_of_packet   (in_end_of_packet),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_section        (out_section),
    .out_payload_value  (out_payload_value),
    .out_last_of_run    (out_last_of_run),
    .out_parse_status   (out_parse_status),
    .out_opcode_seen    (out_opcode_seen),
    .out_block_or_code  (out_block_or_code),
    .out_payload_length (out_payload_length),
    .out_message_kept   (out_message_kept)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  res_t       expected_results[$];
  logic [7:0] frame[$];
  int         errors     = 0;
  int         bytes_sent = 0;
  bit         idle_en    = 1'b1;
  bit         hold_req   = 1'b0;
  bit         holding    = 1'b0;

  // parser state as seen by the predictor
  logic [10:0] pkt_pos    = '0;
  logic [15:0] pkt_opcode = '0;
  logic [1:0]  pkt_phase  = PH_NAME;
  logic [8:0]  str_len    = '0;
  logic [15:0] pkt_code   = '0;
  logic [2:0]  req_error  = ST_OK;

  function automatic res_t payload_result(input logic [1:0] sec, input logic [7:0] b,
                                          input logic last);
    res_t r;
    r = '0;
    r.kind    = RK_PAYLOAD;
    r.section = sec;
    r.value   = b;
    r.last    = last;
    return r;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic eop);
    res_t       r;
    logic [9:0] lim;
    logic [9:0] nxt;
    logic       req;
    logic       pay;
    logic [2:0] st;
    if (pkt_phase == PH_PAYLOAD) begin
      if (pkt_opcode == OP_DATA && pkt_pos < DATA_LIM_W)
        expected_results.push_back(payload_result(SEC_DATA, b, !eop));
      else if (pkt_opcode == OP_ERROR && pkt_pos < MSG_LIM_W - 11'd1)
        expected_results.push_back(payload_result(SEC_ERMSG, b, !eop));
      if (pkt_pos < POS_MAX) pkt_pos++;
    end else begin
      req = (pkt_opcode == OP_RRQ || pkt_opcode == OP_WRQ);
      if (pkt_pos == 11'd0) begin
        pkt_opcode = {b, 8'h00};
      end else if (pkt_pos == 11'd1) begin
        pkt_opcode = {pkt_opcode[15:8], b};
      end else if (req) begin
        if (req_error == ST_OK && pkt_phase != PH_DONE) begin
          lim = (pkt_phase == PH_NAME) ? NAME_LIM_W : MODE_LIM_W;
          if (b == 8'h00) begin
            pkt_phase = (pkt_phase == PH_NAME) ? PH_MODE : PH_DONE;
            str_len   = '0;
          end else begin
            nxt = {1'b0, str_len} + 10'd1;
            if (nxt >= lim) begin
              req_error = (pkt_phase == PH_NAME) ? ST_BAD_NAME : ST_BAD_MODE;
            end else begin
              expected_results.push_back(payload_result(pkt_phase, b, !eop));
              str_len = nxt[8:0];
            end
          end
        end
      end else if (pkt_pos == 11'd2) begin
        pkt_code = {b, 8'h00};
      end else if (pkt_pos == 11'd3) begin
        pkt_code = {pkt_code[15:8], b};
      end
      if (pkt_pos < POS_MAX) pkt_pos++;
      if (pkt_pos == 11'd4 && pkt_opcode >= OP_DATA && pkt_opcode <= OP_ERROR) begin
        pkt_phase = PH_PAYLOAD;
        pkt_pos   = '0;
      end
    end

    if (eop) begin
      pay = (pkt_phase == PH_PAYLOAD);
      if (!pay && pkt_pos < 11'd2) begin
        st = ST_SHORT;
      end else begin
        case (pkt_opcode)
          OP_RRQ, OP_WRQ: begin
            st = req_error;
            if (st == ST_OK && pkt_phase == PH_NAME) st = ST_BAD_NAME;
            else if (st == ST_OK && pkt_phase == PH_MODE) st = ST_BAD_MODE;
          end
          OP_DATA:  st = !pay ? ST_SHORT_HDR : (pkt_pos > DATA_LIM_W ? ST_DATA_LONG : ST_OK);
          OP_ACK:   st = (pay && pkt_pos == 11'd0) ? ST_OK : ST_ACK_LEN;
          OP_ERROR: st = pay ? ST_OK : ST_SHORT_HDR;
          default:  st = ST_BAD_OP;
        endcase
      end
      r = '0;
      r.kind   = RK_STATUS;
      r.last   = 1'b1;
      r.status = st;
      r.opcode = pkt_opcode;
      r.blk    = pay ? pkt_code : 16'd0;
      r.len    = pay ? pkt_pos : (pkt_pos > 11'd4 ? pkt_pos - 11'd4 : 11'd0);
      r.kept   = pay && pkt_opcode == OP_ERROR && pkt_pos >= 11'd1 && pkt_pos < MSG_LIM_W;
      expected_results.push_back(r);
      pkt_pos    = '0;
      pkt_opcode = '0;
      pkt_phase  = PH_NAME;
      str_len    = '0;
      pkt_code   = '0;
      req_error  = ST_OK;
    end
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_checker
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $error("result word with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, out_result_kind);
        check_field("section", want.section, out_section);
        check_field("payload_value", want.value, out_payload_value);
        check_field("last_of_run", want.last, out_last_of_run);
        check_field("parse_status", want.status, out_parse_status);
        check_field("opcode_seen", want.opcode, out_opcode_seen);
        check_field("block_or_code", want.blk, out_block_or_code);
        check_field("payload_length", want.len, out_payload_length);
        check_field("message_kept", want.kept, out_message_kept);
      end
    end
  end

  initial begin : receiver
    int span;
    forever begin
      if (hold_req) begin
        holding = 1'b1;
        out_ready <= 1'b0;
        for (span = 0; span < HOLD_CYCLES; span++) @(posedge clk);
        holding  = 1'b0;
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    if (idle_en && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_packet_byte   <= b;
    in_end_of_packet <= eop;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, eop);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int k;
    for (k = 0; k < frame.size(); k++) send_byte(frame[k], k == frame.size() - 1);
    frame.delete();
  endtask

  // hold the input side until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic add_header(input logic [15:0] op, input logic [15:0] code);
    frame.push_back(op[15:8]);
    frame.push_back(op[7:0]);
    frame.push_back(code[15:8]);
    frame.push_back(code[7:0]);
  endtask

  task automatic add_text(input int n);
    repeat (n) frame.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic add_bytes(input int n);
    repeat (n) frame.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_request(input logic [15:0] op, input int name_len, input int mode_chars);
    frame.push_back(op[15:8]);
    frame.push_back(op[7:0]);
    add_text(name_len);
    frame.push_back(8'h00);
    add_text(mode_chars);
    frame.push_back(8'h00);
  endtask

  function automatic int pick_len(input int lo, input int hi, input int rare_lo,
                                  input int rare_hi, input int odds);
    if ($urandom_range(1, odds) == 1) return $urandom_range(rare_lo, rare_hi);
    return $urandom_range(lo, hi);
  endfunction

  task automatic test_short_packets();
    frame = '{8'h00};               send_frame();
    frame = '{8'hFF};               send_frame();
    frame = '{8'h00, 8'h00};        send_frame();
    frame = '{8'h00, 8'h06};        send_frame();
    frame = '{8'hFF, 8'hFF, 8'h5A}; send_frame();
    frame = '{8'h00, 8'h01};        send_frame();
    drain();
  endtask

  task automatic test_requests();
    frame = '{8'h00, 8'h01, 8'h61, 8'hFF, 8'h00, 8'h6F, 8'h00, 8'h00, 8'hFF};
    send_frame();
    frame = '{8'h00, 8'h02, 8'h78};              send_frame();
    frame = '{8'h00, 8'h02, 8'h78, 8'h00, 8'h01}; send_frame();
    drain();
  endtask

  task automatic test_headers();
    frame = '{8'h00, 8'h03, 8'h12};              send_frame();
    frame = '{8'h00, 8'h03, 8'hFF, 8'hFF};        send_frame();
    frame = '{8'h00, 8'h04, 8'h00, 8'h00};        send_frame();
    frame = '{8'h00, 8'h04, 8'h00, 8'h01, 8'h00}; send_frame();
    frame = '{8'h00, 8'h04, 8'h80};              send_frame();
    frame = '{8'h00, 8'h05, 8'h00, 8'h07};        send_frame();
    frame = '{8'h00, 8'h05, 8'hA5, 8'h5A, 8'hFF}; send_frame();
    drain();
  endtask

  task automatic test_length_limits();
    frame.push_back(8'h00); frame.push_back(8'h01);
    add_text(FILENAME_LIMIT);
    send_frame();
    add_request(OP_RRQ, 3, MODE_LIMIT - 1);
    send_frame();
    add_request(OP_WRQ, 2, MODE_LIMIT);
    send_frame();
    add_header(OP_DATA, 16'hFFFE); add_bytes(DATA_LIMIT + 1); send_frame();
    add_header(OP_ERROR, 16'h0003); add_bytes(MSG_LIMIT);     send_frame();
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    while (!holding) @(posedge clk);
    add_header(OP_DATA, 16'h0042); add_bytes(48); send_frame();
    add_request(OP_WRQ, 6, 5);                   send_frame();
    drain();
  endtask

  task automatic test_random_packets();
    int start;
    int kind;
    int cut;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start > RANDOM_BYTES - CALM_TAIL) idle_en = 1'b0;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          add_request($urandom_range(0, 1) ? OP_RRQ : OP_WRQ,
                      pick_len(0, 12, FILENAME_LIMIT - 6, FILENAME_LIMIT + 2, 20),
                      pick_len(0, 8, MODE_LIMIT - 3, MODE_LIMIT + 1, 12));
          add_bytes($urandom_range(0, 3));
        end
        3, 4: begin
          add_header(OP_DATA, 16'($urandom));
          add_bytes(pick_len(0, 48, DATA_LIMIT - 4, DATA_LIMIT + 4, 25));
        end
        5: begin
          add_header(OP_ACK, 16'($urandom));
          add_bytes(pick_len(0, 0, 1, 3, 4));
        end
        6: begin
          add_header(OP_ERROR, 16'($urandom));
          add_bytes(pick_len(0, 24, MSG_LIMIT - 7, MSG_LIMIT + 3, 25));
        end
        7: begin
          add_header(16'($urandom), 16'($urandom));
          add_bytes($urandom_range(0, 8));
        end
        default: add_bytes($urandom_range(1, 6));
      endcase
      // truncate some packets at a random byte
      if ($urandom_range(0, 9) == 0 && frame.size() > 1) begin
        cut = $urandom_range(1, frame.size() - 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end
      send_frame();
    end
    drain();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_packet_byte   <= 8'h00;
    in_end_of_packet <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_packets();
    test_requests();
    test_headers();
    test_length_limits();
    test_backpressure();
    test_random_packets();
    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("[tftp_packet_parser] OK");
    else
      $display("[tftp_packet_parser] ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[tftp_packet_parser] ERROR");
    $finish;
  end

endmodule
